// File: hdl/nvi_pkg.sv
// nvi_pkg: shared types, constants and helpers of the neville interpolator
// depends on nothing; used by every module of the block
package nvi_pkg;

  localparam int MAX_POINTS = 8;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W     = DATA_W + 1;
  localparam int DVS_W      = DIFF_W;
  localparam int DVD_W      = DIFF_W + FRAC_BITS;
  localparam int MAG_W      = 64;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_EVAL   = 1'b1
  } req_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] query_x;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interp_value;
    logic [1:0]               status;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_APPEND,
    OP_CAPQ,
    OP_SCAN,
    OP_YINIT,
    OP_LD_HO,
    OP_LD_W,
    OP_LD_HP,
    OP_DIV_START,
    OP_MUL_HP,
    OP_FIN_D,
    OP_MUL_HO,
    OP_FIN_C,
    OP_ACC_C,
    OP_ACC_D,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    SRC_ACC,
    SRC_Y,
    SRC_ZERO
  } out_src_t;

  typedef struct packed {
    dp_op_t   op;
    idx_t     addr;
    logic     first;
    out_src_t src;
    status_t  status;
  } dp_cmd_t;

  typedef struct packed {
    logic closer;
    logic den_zero;
    logic div_busy;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_YINIT,
    S_HO,
    S_W,
    S_HP,
    S_DSTART,
    S_DIV,
    S_MULD,
    S_FIND,
    S_MULC,
    S_FINC,
    S_ACC,
    S_OUT
  } ctl_state_t;

  // signed 32-bit value from a magnitude and a sign, saturated
  function automatic logic signed [DATA_W-1:0] from_mag(input logic [MAG_W-1:0] m,
                                                        input logic neg);
    logic [MAG_W-1:0] lim;
    logic [DATA_W-1:0] lo;
    lim = MAG_W'(1) << (DATA_W - 1);
    lo  = m[DATA_W-1:0];
    if (neg) begin
      from_mag = (m > lim) ? {1'b1, {(DATA_W-1){1'b0}}} : -lo;
    end else begin
      from_mag = (m > lim - MAG_W'(1)) ? {1'b0, {(DATA_W-1){1'b1}}} : lo;
    end
  endfunction

  function automatic logic [DIFF_W-1:0] mag_diff(input logic signed [DIFF_W-1:0] v);
    mag_diff = v[DIFF_W-1] ? -v : v;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DIFF_W-1:0] v);
    if (v[DIFF_W-1] != v[DIFF_W-2]) begin
      sat_sum = v[DIFF_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_sum = v[DATA_W-1:0];
    end
  endfunction

endpackage

// File: hdl/nvi_div.sv
// nvi_div: restoring divider, one quotient bit per cycle, saturated signed result
// depends on nvi_pkg
module nvi_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [nvi_pkg::DVD_W-1:0]        dividend,
  input  logic [nvi_pkg::DVS_W-1:0]        divisor,
  input  logic                             neg,
  output logic                             busy,
  output logic signed [nvi_pkg::DATA_W-1:0] quot
);

  localparam int CW = $clog2(nvi_pkg::DVD_W + 1);

  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [nvi_pkg::DVS_W-1:0]   rem_r, rem_nxt;
  logic [nvi_pkg::DVS_W-1:0]   dvs_r;
  logic [nvi_pkg::DVD_W-1:0]   quo_r, quo_nxt;
  logic                        neg_r;
  logic [nvi_pkg::DVS_W:0]     trial;
  logic                        ge;

  assign trial = {rem_r, quo_r[nvi_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt = ge ? nvi_pkg::DVS_W'(trial - {1'b0, dvs_r}) : trial[nvi_pkg::DVS_W-1:0];
    quo_nxt = {quo_r[nvi_pkg::DVD_W-2:0], ge};
    cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(nvi_pkg::DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      neg_r <= neg;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = cnt_r != '0;
  assign quot = nvi_pkg::from_mag(nvi_pkg::MAG_W'(quo_r), neg_r);

endmodule

// File: hdl/nvi_datapath.sv
// nvi_datapath: point tables, tableau columns, subtract, divide and multiply steps
// depends on nvi_pkg and nvi_div
module nvi_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  nvi_pkg::in_t      in_data,
  input  nvi_pkg::dp_cmd_t  cmd,
  output nvi_pkg::dp_stat_t stat,
  output nvi_pkg::out_t     out_data
);

  localparam int DW = nvi_pkg::DATA_W;
  localparam int HW = nvi_pkg::DIFF_W;

  logic signed [DW-1:0] x_mem [nvi_pkg::MAX_POINTS];
  logic signed [DW-1:0] y_mem [nvi_pkg::MAX_POINTS];
  logic signed [DW-1:0] c_mem [nvi_pkg::MAX_POINTS];
  logic signed [DW-1:0] d_mem [nvi_pkg::MAX_POINTS];

  logic signed [DW-1:0] x_rd, y_rd, c_rd, d_rd;
  logic signed [DW-1:0] q_r, acc_r, dj_r;
  logic signed [HW-1:0] ho_r, hp_r, w_r, den_r;
  logic [HW-1:0]        best_r;
  logic [DW-1:0]        rmag_r;
  logic [2*DW-1:0]      prod_r;
  logic                 hi_r, neg_r;
  nvi_pkg::out_t        out_r;

  logic signed [HW-1:0] xq, den_now;
  logic [HW-1:0]        sep, amag, rmag_now;
  logic signed [DW-1:0] r_val, fin_val, add_val;
  logic [2*DW:0]        full;
  logic                 div_busy;

  assign x_rd = x_mem[cmd.addr];
  assign y_rd = y_mem[cmd.addr];
  assign c_rd = c_mem[cmd.addr];
  assign d_rd = d_mem[cmd.addr];

  // x - q, and its distance from the query
  assign xq      = {x_rd[DW-1], x_rd} - {q_r[DW-1], q_r};
  assign sep     = nvi_pkg::mag_diff(xq);
  assign den_now = ho_r - xq;

  assign stat.closer   = cmd.first || (sep < best_r);
  assign stat.den_zero = den_now == '0;
  assign stat.div_busy = div_busy;

  nvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == nvi_pkg::OP_DIV_START),
    .dividend (nvi_pkg::DVD_W'(nvi_pkg::mag_diff(w_r)) << nvi_pkg::FRAC_BITS),
    .divisor  (nvi_pkg::mag_diff(den_r)),
    .neg      (w_r[HW-1] ^ den_r[HW-1]),
    .busy     (div_busy),
    .quot     (r_val)
  );

  // multiplier operand: hp or ho, split into low word and top bit
  assign amag     = nvi_pkg::mag_diff((cmd.op == nvi_pkg::OP_MUL_HP) ? hp_r : ho_r);
  assign rmag_now = nvi_pkg::mag_diff({r_val[DW-1], r_val});

  always_comb begin
    full    = {1'b0, prod_r} + (hi_r ? {1'b0, rmag_r, {DW{1'b0}}} : '0);
    fin_val = nvi_pkg::from_mag(nvi_pkg::MAG_W'(full >> nvi_pkg::FRAC_BITS), neg_r);
    add_val = (cmd.op == nvi_pkg::OP_ACC_C) ? c_rd : d_rd;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      nvi_pkg::OP_APPEND: begin
        x_mem[cmd.addr] <= in_data.point_x;
        y_mem[cmd.addr] <= in_data.point_y;
      end
      nvi_pkg::OP_CAPQ: q_r <= in_data.query_x;
      nvi_pkg::OP_SCAN: begin
        c_mem[cmd.addr] <= y_rd;
        d_mem[cmd.addr] <= y_rd;
        if (stat.closer) best_r <= sep;
      end
      nvi_pkg::OP_YINIT: acc_r <= y_rd;
      nvi_pkg::OP_LD_HO: begin
        ho_r <= xq;
        dj_r <= d_rd;
      end
      nvi_pkg::OP_LD_W: w_r <= {c_rd[DW-1], c_rd} - {dj_r[DW-1], dj_r};
      nvi_pkg::OP_LD_HP: begin
        hp_r  <= xq;
        den_r <= den_now;
      end
      nvi_pkg::OP_MUL_HP, nvi_pkg::OP_MUL_HO: begin
        prod_r <= amag[DW-1:0] * rmag_now[DW-1:0];
        rmag_r <= rmag_now[DW-1:0];
        hi_r   <= amag[DW];
        neg_r  <= ((cmd.op == nvi_pkg::OP_MUL_HP) ? hp_r[HW-1] : ho_r[HW-1]) ^ r_val[DW-1];
      end
      nvi_pkg::OP_FIN_D: d_mem[cmd.addr] <= fin_val;
      nvi_pkg::OP_FIN_C: c_mem[cmd.addr] <= fin_val;
      nvi_pkg::OP_ACC_C, nvi_pkg::OP_ACC_D:
        acc_r <= nvi_pkg::sat_sum({acc_r[DW-1], acc_r} + {add_val[DW-1], add_val});
      nvi_pkg::OP_OUT: begin
        out_r.status <= cmd.status;
        unique case (cmd.src)
          nvi_pkg::SRC_ACC: out_r.interp_value <= acc_r;
          nvi_pkg::SRC_Y:   out_r.interp_value <= y_rd;
          default:          out_r.interp_value <= '0;
        endcase
      end
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

// File: hdl/nvi_ctrl.sv
// nvi_ctrl: sequencer over the tableau, point count and handshakes
// depends on nvi_pkg
module nvi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  nvi_pkg::dp_stat_t stat,
  output nvi_pkg::dp_cmd_t  cmd
);

  localparam int CW1 = nvi_pkg::CNT_W + 1;

  nvi_pkg::ctl_state_t state_r, state_nxt;
  nvi_pkg::idx_t       j_r, j_nxt, k_r, k_nxt, m_r, m_nxt;
  nvi_pkg::cnt_t       n_r, n_nxt;
  logic                ovf_r, ovf_nxt, out_valid_r, out_valid_nxt;
  nvi_pkg::out_src_t   src_r, src_nxt;
  nvi_pkg::status_t    st_r, st_nxt;

  logic          in_go, out_go, scan_last, row_last, col_last, use_c;
  nvi_pkg::cnt_t n_m1;

  assign in_go     = in_valid && (state_r == nvi_pkg::S_IDLE);
  assign out_go    = !out_valid_r || !out_stall;
  assign n_m1      = n_r - nvi_pkg::cnt_t'(1);
  assign scan_last = nvi_pkg::cnt_t'(j_r) == n_m1;
  assign row_last  = nvi_pkg::cnt_t'(j_r) + nvi_pkg::cnt_t'(m_r) == n_m1;
  assign col_last  = nvi_pkg::cnt_t'(m_r) == n_m1;
  assign use_c     = (CW1'(k_r) << 1) < CW1'(n_r - nvi_pkg::cnt_t'(m_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nvi_pkg::S_IDLE:
        if (in_go && in_req_type == nvi_pkg::REQ_EVAL) begin
          state_nxt = (n_r == '0) ? nvi_pkg::S_OUT : nvi_pkg::S_SCAN;
        end
      nvi_pkg::S_SCAN:   if (scan_last) state_nxt = nvi_pkg::S_YINIT;
      nvi_pkg::S_YINIT:  state_nxt = (n_r == nvi_pkg::cnt_t'(1)) ? nvi_pkg::S_OUT : nvi_pkg::S_HO;
      nvi_pkg::S_HO:     state_nxt = nvi_pkg::S_W;
      nvi_pkg::S_W:      state_nxt = nvi_pkg::S_HP;
      nvi_pkg::S_HP:     state_nxt = stat.den_zero ? nvi_pkg::S_OUT : nvi_pkg::S_DSTART;
      nvi_pkg::S_DSTART: state_nxt = nvi_pkg::S_DIV;
      nvi_pkg::S_DIV:    if (!stat.div_busy) state_nxt = nvi_pkg::S_MULD;
      nvi_pkg::S_MULD:   state_nxt = nvi_pkg::S_FIND;
      nvi_pkg::S_FIND:   state_nxt = nvi_pkg::S_MULC;
      nvi_pkg::S_MULC:   state_nxt = nvi_pkg::S_FINC;
      nvi_pkg::S_FINC:   state_nxt = row_last ? nvi_pkg::S_ACC : nvi_pkg::S_HO;
      nvi_pkg::S_ACC:    state_nxt = col_last ? nvi_pkg::S_OUT : nvi_pkg::S_HO;
      nvi_pkg::S_OUT:    if (out_go) state_nxt = nvi_pkg::S_IDLE;
      default:           state_nxt = nvi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '{op: nvi_pkg::OP_NONE, addr: j_r, first: 1'b0,
                      src: src_r, status: st_r};
    j_nxt         = j_r;
    k_nxt         = k_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    src_nxt       = src_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      nvi_pkg::S_IDLE:
        if (in_go) begin
          if (in_req_type == nvi_pkg::REQ_APPEND) begin
            if (n_r < nvi_pkg::cnt_t'(nvi_pkg::MAX_POINTS)) begin
              cmd.op   = nvi_pkg::OP_APPEND;
              cmd.addr = n_r[nvi_pkg::IDX_W-1:0];
              n_nxt    = n_r + nvi_pkg::cnt_t'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            cmd.op  = nvi_pkg::OP_CAPQ;
            j_nxt   = '0;
            k_nxt   = '0;
            src_nxt = nvi_pkg::SRC_ZERO;
            st_nxt  = nvi_pkg::ST_EMPTY;
          end
        end
      nvi_pkg::S_SCAN: begin
        cmd.op    = nvi_pkg::OP_SCAN;
        cmd.first = j_r == '0;
        if (stat.closer) k_nxt = j_r;
        j_nxt = scan_last ? '0 : j_r + nvi_pkg::idx_t'(1);
      end
      nvi_pkg::S_YINIT: begin
        cmd.op   = nvi_pkg::OP_YINIT;
        cmd.addr = k_r;
        m_nxt    = nvi_pkg::idx_t'(1);
        src_nxt  = nvi_pkg::SRC_ACC;
        st_nxt   = ovf_r ? nvi_pkg::ST_DROPPED : nvi_pkg::ST_OK;
      end
      nvi_pkg::S_HO: cmd.op = nvi_pkg::OP_LD_HO;
      nvi_pkg::S_W: begin
        cmd.op   = nvi_pkg::OP_LD_W;
        cmd.addr = j_r + nvi_pkg::idx_t'(1);
      end
      nvi_pkg::S_HP: begin
        cmd.op   = nvi_pkg::OP_LD_HP;
        cmd.addr = j_r + m_r;
        if (stat.den_zero) begin
          src_nxt = nvi_pkg::SRC_Y;
          st_nxt  = nvi_pkg::ST_DUP;
        end
      end
      nvi_pkg::S_DSTART: cmd.op = nvi_pkg::OP_DIV_START;
      nvi_pkg::S_DIV:    ;
      nvi_pkg::S_MULD:   cmd.op = nvi_pkg::OP_MUL_HP;
      nvi_pkg::S_FIND:   cmd.op = nvi_pkg::OP_FIN_D;
      nvi_pkg::S_MULC:   cmd.op = nvi_pkg::OP_MUL_HO;
      nvi_pkg::S_FINC: begin
        cmd.op = nvi_pkg::OP_FIN_C;
        j_nxt  = row_last ? '0 : j_r + nvi_pkg::idx_t'(1);
      end
      nvi_pkg::S_ACC: begin
        if (use_c) begin
          cmd.op   = nvi_pkg::OP_ACC_C;
          cmd.addr = k_r;
        end else begin
          cmd.op   = nvi_pkg::OP_ACC_D;
          cmd.addr = k_r - nvi_pkg::idx_t'(1);
          k_nxt    = k_r - nvi_pkg::idx_t'(1);
        end
        m_nxt = m_r + nvi_pkg::idx_t'(1);
      end
      nvi_pkg::S_OUT:
        if (out_go) begin
          cmd.op        = nvi_pkg::OP_OUT;
          cmd.addr      = nvi_pkg::idx_t'(1);
          out_valid_nxt = 1'b1;
          n_nxt         = '0;
          ovf_nxt       = 1'b0;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nvi_pkg::S_IDLE;
      n_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      k_r         <= '0;
      m_r         <= '0;
      src_r       <= nvi_pkg::SRC_ZERO;
      st_r        <= nvi_pkg::ST_EMPTY;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      m_r         <= m_nxt;
      src_r       <= src_nxt;
      st_r        <= st_nxt;
    end
  end

  assign in_stall  = state_r != nvi_pkg::S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: hdl/neville_polynomial_interpolator_core.sv
// Neville polynomial interpolator, signed Q16.16 fixed point.
// Input channel in_valid/in_stall/in_data: an append request stores
// (point_x, point_y) in the next free slot of an 8-entry table, or sets a
// dropped flag when full; an evaluate request runs the tableau at query_x.
// Result channel out_valid/out_stall/out_data: one result per evaluate,
// none per append. An evaluate with n points runs a nearest-point scan
// and setup, then n(n-1)/2 tableau updates, each led by the bit-serial
// divider at one quotient bit per cycle (49 bits), then an accumulate
// step per column and a load of the output register; an empty table or
// duplicate abscissae end early.
// The result sits in an output register, so appends are taken while it
// waits; a second evaluate is taken and computed, then holds in_stall high
// until the register empties. While an evaluation runs in_stall is high.
// After each evaluation the table and the dropped flag are cleared.
// Reset (rst_n low, synchronous) empties the table and the result register.
// depends on nvi_pkg, nvi_ctrl, nvi_datapath
module neville_polynomial_interpolator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nvi_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nvi_pkg::out_t out_data
);

  nvi_pkg::dp_cmd_t  cmd;
  nvi_pkg::dp_stat_t stat;

  nvi_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  nvi_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: hdl/nvi_checker.sv
// nvi_checker: port-level assertions for the interpolator, bound to the top level
// depends on nvi_pkg and neville_polynomial_interpolator_core
module nvi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input nvi_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input nvi_pkg::out_t out_data
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an evaluate request keeps the block busy next cycle
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == nvi_pkg::REQ_EVAL |=> in_stall)
    else $error("evaluate request did not occupy the block");

  // an append never produces a result
  a_append_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == nvi_pkg::REQ_APPEND && !out_valid
    |=> !out_valid)
    else $error("append request produced a result");

  // a new result only comes out of an evaluation in progress
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

endmodule

bind neville_polynomial_interpolator_core nvi_checker u_nvi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/tb_neville_polynomial_interpolator_core.sv
// testbench for neville_polynomial_interpolator_core: directed table, then random
// point sets ending in an evaluate; results checked against an in-bench tableau predictor
// depends on nvi_pkg and neville_polynomial_interpolator_core
`timescale 1ns / 100ps

module tb_neville_polynomial_interpolator_core;

  typedef struct {
    nvi_pkg::in_t  req;
    bit            typed;
    nvi_pkg::out_t want;
  } step_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  nvi_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  nvi_pkg::out_t out_data;

  nvi_pkg::out_t pending_results[$];
  step_row_t     step_table[$];
  int            fail_count = 0;
  bit            calm = 1'b0;

  // predictor copy of the point table
  longint pt_x[nvi_pkg::MAX_POINTS];
  longint pt_y[nvi_pkg::MAX_POINTS];
  int     pt_count = 0;
  bit     pt_dropped = 1'b0;

  neville_polynomial_interpolator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  initial begin
    #40_000_000;
    $display("neville_polynomial_interpolator_core verification failed");
    $finish;
  end

  function automatic logic [63:0] abs_val(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint clamp_signed(logic [63:0] m, bit neg);
    if (neg) return (m > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(m);
    return (m > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // neville tableau starting from the nearest point, in fixed point
  function automatic nvi_pkg::out_t neville_eval(longint q);
    longint c[nvi_pkg::MAX_POINTS];
    longint d[nvi_pkg::MAX_POINTS];
    longint acc, ho, hp, den, w, r;
    logic [63:0] best, span;
    int n, k;
    nvi_pkg::out_t res;
    n = pt_count;
    k = 0;
    if (n == 0) begin
      res.interp_value = '0;
      res.status = nvi_pkg::ST_EMPTY;
      return res;
    end
    best = abs_val(q - pt_x[0]);
    for (int j = 0; j < n; j++) begin
      span = abs_val(q - pt_x[j]);
      if (span < best) begin
        best = span;
        k = j;
      end
      c[j] = pt_y[j];
      d[j] = pt_y[j];
    end
    acc = pt_y[k];
    for (int m = 1; m < n; m++) begin
      for (int j = 0; j + m < n; j++) begin
        ho = pt_x[j] - q;
        hp = pt_x[j + m] - q;
        den = ho - hp;
        w = c[j + 1] - d[j];
        if (den == 0) begin
          res.interp_value = pt_y[1][31:0];
          res.status = nvi_pkg::ST_DUP;
          return res;
        end
        r = clamp_signed((abs_val(w) << nvi_pkg::FRAC_BITS) / abs_val(den),
                         (w < 0) != (den < 0));
        d[j] = clamp_signed((abs_val(hp) * abs_val(r)) >> nvi_pkg::FRAC_BITS,
                            (hp < 0) != (r < 0));
        c[j] = clamp_signed((abs_val(ho) * abs_val(r)) >> nvi_pkg::FRAC_BITS,
                            (ho < 0) != (r < 0));
      end
      if (2 * k < n - m) begin
        acc = clamp32(acc + c[k]);
      end else begin
        acc = clamp32(acc + d[k - 1]);
        k--;
      end
    end
    res.interp_value = acc[31:0];
    res.status = pt_dropped ? nvi_pkg::ST_DROPPED : nvi_pkg::ST_OK;
    return res;
  endfunction

  // applies one accepted request to the predictor; returns 1 when a result follows
  function automatic bit apply_request(nvi_pkg::in_t req, output nvi_pkg::out_t res);
    res = '0;
    if (req.req_type == nvi_pkg::REQ_APPEND) begin
      if (pt_count < nvi_pkg::MAX_POINTS) begin
        pt_x[pt_count] = longint'(req.point_x);
        pt_y[pt_count] = longint'(req.point_y);
        pt_count++;
      end else begin
        pt_dropped = 1'b1;
      end
      return 1'b0;
    end
    res = neville_eval(longint'(req.query_x));
    pt_count = 0;
    pt_dropped = 1'b0;
    return 1'b1;
  endfunction

  function automatic nvi_pkg::in_t make_req(logic kind, int x, int y, int q);
    nvi_pkg::in_t r;
    r.req_type = kind;
    r.point_x = x;
    r.point_y = y;
    r.query_x = q;
    return r;
  endfunction

  function automatic void add_row(nvi_pkg::in_t req, bit typed = 1'b0,
                                  nvi_pkg::out_t want = '0);
    step_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = want;
    step_table.push_back(row);
  endfunction

  task automatic send_request(nvi_pkg::in_t req, bit typed = 1'b0,
                              nvi_pkg::out_t want = '0);
    nvi_pkg::out_t res;
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    if (apply_request(req, res)) pending_results.push_back(typed ? want : res);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      in_data <= make_req(1'($urandom), $urandom, $urandom, $urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stops sending and waits until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  function automatic int pick_x(int center, int prev);
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return prev;  // repeated abscissa
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return center + int'($urandom_range(0, 16 << 16)) - (8 << 16);
    endcase
  endfunction

  function automatic int pick_y();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 200 << 16)) - (100 << 16);
    endcase
  endfunction

  // receiver stall bursts
  always begin
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 13)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result value=%h status=%0d", out_data.interp_value,
               out_data.status);
        fail_count++;
      end else begin
        nvi_pkg::out_t want;
        want = pending_results.pop_front();
        if (out_data.interp_value !== want.interp_value) begin
          $error("interp_value expected %h actual %h", want.interp_value,
                 out_data.interp_value);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    nvi_pkg::out_t want;
    int sent, npts, center, prev_x;
    in_data = make_req(nvi_pkg::REQ_APPEND, 0, 0, 0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    want.interp_value = '0;
    want.status = nvi_pkg::ST_EMPTY;
    add_row(make_req(nvi_pkg::REQ_EVAL, 0, 0, 32'h8000_0000), 1'b1, want);
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'h0001_0000, 32'h0005_0000, 0));
    want.interp_value = 32'h0005_0000;
    want.status = nvi_pkg::ST_OK;
    add_row(make_req(nvi_pkg::REQ_EVAL, 0, 0, 32'h7FFF_FFFF), 1'b1, want);
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    add_row(make_req(nvi_pkg::REQ_APPEND, 0, 32'h7FFF_FFFF, 0));
    add_row(make_req(nvi_pkg::REQ_EVAL, 0, 0, 32'h4000_0000));
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'h0003_0000, 32'h000A_0000, 0));
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'h0003_0000, 32'hFFEC_0000, 0));
    want.interp_value = 32'hFFEC_0000;
    want.status = nvi_pkg::ST_DUP;
    add_row(make_req(nvi_pkg::REQ_EVAL, 0, 0, 32'h0001_0000), 1'b1, want);
    // one point past capacity, then evaluate with the dropped status
    for (int i = 0; i <= nvi_pkg::MAX_POINTS; i++)
      add_row(make_req(nvi_pkg::REQ_APPEND, (i - 4) << 16, (i * i) << 14, 0));
    add_row(make_req(nvi_pkg::REQ_EVAL, 0, 0, 32'h0000_8000));
    // equidistant points, first one wins the tie
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'hFFFF_0000, 32'h0002_0000, 0));
    add_row(make_req(nvi_pkg::REQ_APPEND, 32'h0001_0000, 32'h0006_0000, 0));
    add_row(make_req(nvi_pkg::REQ_EVAL, 0, 0, 0));
    foreach (step_table[i]) send_request(step_table[i].req, step_table[i].typed,
                                         step_table[i].want);
    sent = step_table.size();
    drain_results();

    // random point sets, each closed by an evaluate
    while (sent < 500) begin
      if (sent > 440) calm = 1'b1;
      npts = $urandom_range(0, 9) == 0 ? $urandom_range(0, nvi_pkg::MAX_POINTS + 3)
                                       : $urandom_range(1, nvi_pkg::MAX_POINTS);
      center = $urandom_range(0, 3) == 0 ? $urandom : int'($urandom_range(0, 64 << 16));
      prev_x = center;
      for (int i = 0; i < npts; i++) begin
        prev_x = pick_x(center, prev_x);
        send_request(make_req(nvi_pkg::REQ_APPEND, prev_x, pick_y(), $urandom));
        sent++;
      end
      send_request(make_req(nvi_pkg::REQ_EVAL, $urandom, $urandom,
                            $urandom_range(0, 3) == 0 ? $urandom : pick_x(center, prev_x)));
      sent++;
      // let the block drain completely now and then
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("neville_polynomial_interpolator_core verification clean");
    end else begin
      $display("neville_polynomial_interpolator_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/nvi_pkg.sv
hdl/nvi_div.sv
hdl/nvi_datapath.sv
hdl/nvi_ctrl.sv
hdl/neville_polynomial_interpolator_core.sv
hdl/nvi_checker.sv
verif/tb_neville_polynomial_interpolator_core.sv
